// ===== design/byte_ring_buffer_with_insert_remove_defines.svh =====
// Assertion macros used by the checker of the byte ring buffer.
`ifndef BYTE_RING_BUFFER_WITH_INSERT_REMOVE_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BRB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("brb assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("brb assertion failed");

`endif

// ===== design/brb_pkg.sv =====
// Package of the byte ring buffer: widths, opcodes, status codes, cell control types.
package brb_pkg;

    localparam int DATA_W    = 8;
    localparam int FILL_W    = 9;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 256;
    localparam int GROUP     = 16;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd5;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADP  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_COLLECT
    } t_state;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_PUSH,
        CC_SHIFT_DN,
        CC_INSERT,
        CC_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [FILL_W-1:0] pos;
        logic [FILL_W-1:0] rd_pos;
        logic [DATA_W-1:0] din;
    } t_cell_ctl;

endpackage

// ===== design/brb_cell.sv =====
// One byte cell of the row: holds the byte at one offset from the oldest entry.
module brb_cell #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                        i_clk,
    input  brb_pkg::t_cell_ctl          i_ctl,
    input  logic [brb_pkg::DATA_W-1:0]  i_left,
    input  logic [brb_pkg::DATA_W-1:0]  i_right,
    output logic [brb_pkg::DATA_W-1:0]  o_byte,
    output logic [brb_pkg::DATA_W-1:0]  o_sel
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((IW > brb_pkg::FILL_W) ? IW : brb_pkg::FILL_W) + 1;
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [brb_pkg::DATA_W-1:0] r_byte;
    logic [brb_pkg::DATA_W-1:0] n_byte;
    logic [CW-1:0]              pos_ext;
    logic [CW-1:0]              rd_ext;

    assign pos_ext = CW'(i_ctl.pos);
    assign rd_ext  = CW'(i_ctl.rd_pos);

    always_comb begin
        n_byte = r_byte;
        unique case (i_ctl.cmd)
            brb_pkg::CC_HOLD:     n_byte = r_byte;
            brb_pkg::CC_PUSH:     if (IDX_C == pos_ext) n_byte = i_ctl.din;
            brb_pkg::CC_SHIFT_DN: n_byte = i_right;
            brb_pkg::CC_INSERT: begin
                if (IDX_C == pos_ext)
                    n_byte = i_ctl.din;
                else if (IDX_C > pos_ext)
                    n_byte = i_left;
            end
            brb_pkg::CC_REMOVE:   if (IDX_C >= pos_ext) n_byte = i_right;
            default:              n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_sel  = (IDX_C == rd_ext) ? r_byte : '0;

endmodule

// ===== design/byte_ring_buffer_with_insert_remove.sv =====
// Top level of the byte ring buffer: sequencer, cell row and read-out tree.
//
//  channel   direction  handshake                   payload
//  command   in         i_start, o_busy             i_opcode i_data_in i_position i_count
//  result    out        o_valid (one-cycle strobe)  o_data_out o_status o_fill o_moved
//  config    in         i_cfg_we                    i_cfg_wdata (capacity)
//
// An item is taken when i_start is high and o_busy low; o_busy stays high in S_EXEC and
// S_COLLECT; the result strobes as o_busy falls, when the next item may already be taken.
// A drop of n > 1 bytes goes via S_SHIFT too: the cell row moves one slot per cycle.
// Peek, pop and remove read through a two-level registered OR tree of GROUP-wide groups.
// i_rst_n (synchronous, low) clears the sequencer and fill; the byte store is undefined
// until written. The receiver cannot stall: o_valid marks each result for one cycle only.
module byte_ring_buffer_with_insert_remove #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [brb_pkg::OP_W-1:0]    i_opcode,
    input  logic [brb_pkg::DATA_W-1:0]  i_data_in,
    input  logic [brb_pkg::FILL_W-1:0]  i_position,
    input  logic [brb_pkg::FILL_W-1:0]  i_count,
    output logic                        o_valid,
    output logic [brb_pkg::DATA_W-1:0]  o_data_out,
    output logic [brb_pkg::STAT_W-1:0]  o_status,
    output logic [brb_pkg::FILL_W-1:0]  o_fill,
    output logic [brb_pkg::FILL_W-1:0]  o_moved,
    input  logic                        i_cfg_we,
    input  logic [brb_pkg::FILL_W-1:0]  i_cfg_wdata
);

    localparam int FW    = brb_pkg::FILL_W;
    localparam int DW    = brb_pkg::DATA_W;
    localparam int GRP   = brb_pkg::GROUP;
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam int FMAX  = (1 << FW) - 1;
    localparam logic [FW:0] CAP_MAX = (FW+1)'((DEPTH > FMAX) ? FMAX : DEPTH);

    brb_pkg::t_state r_state;
    brb_pkg::t_state n_state;

    logic [brb_pkg::OP_W-1:0] r_op;
    logic [DW-1:0]            r_din;
    logic [FW-1:0]            r_pos;
    logic [FW-1:0]            r_cnt;
    logic [FW-1:0]            r_capacity;
    logic [FW-1:0]            r_fill;
    logic [FW-1:0]            n_fill;
    logic [FW-1:0]            r_left;
    logic [FW-1:0]            n_left;
    logic [brb_pkg::STAT_W-1:0] r_status;
    logic [brb_pkg::STAT_W-1:0] n_status;
    logic [FW-1:0]            r_moved;
    logic [FW-1:0]            n_moved;
    logic                     r_rd_ok;
    logic                     n_rd_ok;

    logic                     r_out_valid;
    logic [DW-1:0]            r_out_data;
    logic [brb_pkg::STAT_W-1:0] r_out_status;
    logic [FW-1:0]            r_out_fill;
    logic [FW-1:0]            r_out_moved;

    logic [FW-1:0]            cap_eff;
    logic [FW-1:0]            drop_mv;
    brb_pkg::t_cell_ctl       cell_ctl;

    logic [DW-1:0] cell_q   [DEPTH];
    logic [DW-1:0] cell_sel [DEPTH];
    logic [DW-1:0] nb_left  [DEPTH];
    logic [DW-1:0] nb_right [DEPTH];
    logic [DW-1:0] r_grp    [NGRP];
    logic [DW-1:0] tree_out;

    // Clamp capacity to 1..DEPTH, and to no more than 2**FILL_W-1.
    always_comb begin
        if (r_capacity == '0)
            cap_eff = FW'(1);
        else if ({1'b0, r_capacity} > CAP_MAX)
            cap_eff = CAP_MAX[FW-1:0];
        else
            cap_eff = r_capacity;
    end

    assign drop_mv = (r_cnt > r_fill) ? r_fill : r_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brb_pkg::S_IDLE:    if (i_start) n_state = brb_pkg::S_EXEC;
            brb_pkg::S_EXEC: begin
                if (r_op == brb_pkg::OP_DROP && drop_mv > FW'(1))
                    n_state = brb_pkg::S_SHIFT;
                else
                    n_state = brb_pkg::S_COLLECT;
            end
            brb_pkg::S_SHIFT:   if (r_left == FW'(1)) n_state = brb_pkg::S_COLLECT;
            brb_pkg::S_COLLECT: n_state = brb_pkg::S_IDLE;
            default:            n_state = brb_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: cell command and result bookkeeping.
    always_comb begin
        o_busy          = (r_state != brb_pkg::S_IDLE);
        cell_ctl.cmd    = brb_pkg::CC_HOLD;
        cell_ctl.pos    = r_pos;
        cell_ctl.rd_pos = (r_op == brb_pkg::OP_POP) ? '0 : r_pos;
        cell_ctl.din    = r_din;
        n_fill          = r_fill;
        n_left          = r_left;
        n_status        = r_status;
        n_moved         = r_moved;
        n_rd_ok         = r_rd_ok;
        unique case (r_state)
            brb_pkg::S_EXEC: begin
                n_status = brb_pkg::STAT_OK;
                n_moved  = '0;
                n_rd_ok  = 1'b0;
                case (r_op)
                    brb_pkg::OP_PUSH: begin
                        if (r_fill >= cap_eff) begin
                            n_status = brb_pkg::STAT_FULL;
                        end else begin
                            cell_ctl.cmd = brb_pkg::CC_PUSH;
                            cell_ctl.pos = r_fill;
                            n_fill       = r_fill + FW'(1);
                            n_moved      = FW'(1);
                        end
                    end
                    brb_pkg::OP_POP: begin
                        if (r_fill == '0) begin
                            n_status = brb_pkg::STAT_EMPTY;
                        end else begin
                            cell_ctl.cmd = brb_pkg::CC_SHIFT_DN;
                            n_fill       = r_fill - FW'(1);
                            n_moved      = FW'(1);
                            n_rd_ok      = 1'b1;
                        end
                    end
                    brb_pkg::OP_PEEK, brb_pkg::OP_REMOVE: begin
                        if (r_pos > r_fill) begin
                            n_status = brb_pkg::STAT_BADP;
                        end else if (r_fill == '0) begin
                            n_status = brb_pkg::STAT_EMPTY;
                        end else if (r_pos == r_fill) begin
                            n_status = brb_pkg::STAT_BADP;
                        end else begin
                            n_moved = FW'(1);
                            n_rd_ok = 1'b1;
                            if (r_op == brb_pkg::OP_REMOVE) begin
                                cell_ctl.cmd = brb_pkg::CC_REMOVE;
                                n_fill       = r_fill - FW'(1);
                            end
                        end
                    end
                    brb_pkg::OP_INSERT: begin
                        if (r_pos > r_fill) begin
                            n_status = brb_pkg::STAT_BADP;
                        end else if (r_fill >= cap_eff) begin
                            n_status = brb_pkg::STAT_FULL;
                        end else begin
                            cell_ctl.cmd = brb_pkg::CC_INSERT;
                            n_fill       = r_fill + FW'(1);
                            n_moved      = FW'(1);
                        end
                    end
                    brb_pkg::OP_FLUSH: begin
                        n_moved = r_fill;
                        n_fill  = '0;
                    end
                    brb_pkg::OP_DROP: begin
                        n_moved = drop_mv;
                        n_fill  = r_fill - drop_mv;
                        if (drop_mv != '0) begin
                            cell_ctl.cmd = brb_pkg::CC_SHIFT_DN;
                            n_left       = drop_mv - FW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            brb_pkg::S_SHIFT: begin
                cell_ctl.cmd = brb_pkg::CC_SHIFT_DN;
                n_left       = r_left - FW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brb_pkg::S_IDLE;
            r_fill      <= '0;
            r_capacity  <= CAP_MAX[FW-1:0];
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= (r_state == brb_pkg::S_COLLECT);
            // A capacity write empties the buffer.
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
                r_fill     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == brb_pkg::S_IDLE && i_start) begin
            r_op  <= i_opcode;
            r_din <= i_data_in;
            r_pos <= i_position;
            r_cnt <= i_count;
        end
        r_left   <= n_left;
        r_status <= n_status;
        r_moved  <= n_moved;
        r_rd_ok  <= n_rd_ok;
        if (r_state == brb_pkg::S_COLLECT) begin
            r_out_data   <= r_rd_ok ? tree_out : '0;
            r_out_status <= r_status;
            r_out_fill   <= r_fill;
            r_out_moved  <= r_moved;
        end
    end

    // Cell row; the end cells see zero beyond the row.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign nb_left[i] = '0;
        end else begin : g_inner_l
            assign nb_left[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign nb_right[i] = '0;
        end else begin : g_inner_r
            assign nb_right[i] = cell_q[i+1];
        end
        brb_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_left  (nb_left[i]),
            .i_right (nb_right[i]),
            .o_byte  (cell_q[i]),
            .o_sel   (cell_sel[i])
        );
    end

    // First tree level: register the OR of each group, sampled before the cells update.
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [DW-1:0] acc;
        always_comb begin
            acc = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH)
                    acc = acc | cell_sel[g * GRP + j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_grp[g] <= acc;
        end
    end

    always_comb begin
        tree_out = '0;
        for (int g = 0; g < NGRP; g++)
            tree_out = tree_out | r_grp[g];
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_status   = r_out_status;
    assign o_fill     = r_out_fill;
    assign o_moved    = r_out_moved;

endmodule

// ===== design/brb_checker.sv =====
// Port-level checker of the byte ring buffer, bound to the top level.
`include "byte_ring_buffer_with_insert_remove_defines.svh"

module brb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic [brb_pkg::DATA_W-1:0]  o_data_out,
    input logic [brb_pkg::STAT_W-1:0]  o_status,
    input logic [brb_pkg::FILL_W-1:0]  o_fill,
    input logic [brb_pkg::FILL_W-1:0]  o_moved
);

    // A taken item keeps the block busy in the next cycle.
    `BRB_ASSERT_NEXT(a_start_busy, i_start && !o_busy, o_busy)
    // The block is free again when its result strobes.
    `BRB_ASSERT_NOW(a_valid_idle, o_valid, !o_busy)
    // An error moves nothing and returns no data.
    `BRB_ASSERT_NOW(a_err_quiet, o_valid && o_status != brb_pkg::STAT_OK,
        o_moved == '0 && o_data_out == '0)
    // Empty is only reported with nothing held.
    `BRB_ASSERT_NOW(a_empty_fill, o_valid && o_status == brb_pkg::STAT_EMPTY, o_fill == '0)

endmodule

bind byte_ring_buffer_with_insert_remove brb_checker u_brb_checker (.*);
